/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* rtl/core/kwsm_pkg.sv */
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared types and codes of the k-way sorted merge engine.
// ----------------------------------------------------------------------------
package kwsm_pkg;

    localparam int OP_WIDTH     = 2;
    localparam int INDEX_WIDTH  = 3;
    localparam int STATUS_WIDTH = 2;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_LOAD  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REFRESH
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic refresh;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic needs_refresh;
    } dp_stat_t;

endpackage

/* rtl/core/kwsm_req_if.sv */
// ----------------------------------------------------------------------------
// kwsm_req_if
// Request channel: operation, list index and value.
// ----------------------------------------------------------------------------
interface kwsm_req_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [kwsm_pkg::OP_WIDTH-1:0]        op;
    logic [kwsm_pkg::INDEX_WIDTH-1:0]     list_index;
    logic signed [VALUE_WIDTH-1:0]        value;

    modport source (output valid, op, list_index, value, input ready);
    modport sink   (input valid, op, list_index, value, output ready);
endinterface

/* rtl/core/kwsm_rsp_if.sv */
// ----------------------------------------------------------------------------
// kwsm_rsp_if
// Response channel: popped value, its valid flag and status.
// ----------------------------------------------------------------------------
interface kwsm_rsp_if #(
    parameter int VALUE_WIDTH = 16
);
    logic                                 valid;
    logic                                 ready;
    logic signed [VALUE_WIDTH-1:0]        out_value;
    logic                                 out_valid;
    logic [kwsm_pkg::STATUS_WIDTH-1:0]    status;

    modport source (output valid, out_value, out_valid, status, input ready);
    modport sink   (input valid, out_value, out_valid, status, output ready);
endinterface

/* rtl/core/k_way_sorted_merge.sv */
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merge engine over NUM_LISTS FIFOs; each pop returns the smallest front.
//
//   channel  dir  payload                         transaction
//   req      in   op, list_index, value           one load, pop or clear
//   rsp      out  out_value, out_valid, status    one per request
//
// Load, clear and unknown ops go from accept through execute back to idle;
// a pop that leaves its list non-empty adds a refresh step: the
// element memory read that refreshes the cached front of that list.
// The front minimum is a combinational comparator tree over the cached fronts.
// A request is taken while the previous response still waits; execution
// stalls until the response register is free. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module k_way_sorted_merge #(
    parameter int NUM_LISTS   = 8,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    kwsm_req_if.sink    req,
    kwsm_rsp_if.source  rsp
);

    kwsm_pkg::ctrl_cmd_t cmd;
    kwsm_pkg::dp_stat_t  stat;

    kwsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    kwsm_dp #(
        .NUM_LISTS   (NUM_LISTS),
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (req.op),
        .list_index (req.list_index),
        .value      (req.value),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .out_value  (rsp.out_value),
        .out_valid  (rsp.out_valid),
        .status     (rsp.status)
    );

    `ASSERT_NEVER(a_no_accept_while_busy, clk, rst_n, req.ready && (cmd.exec || cmd.refresh))
    `ASSERT_CLK(a_refresh_after_exec, clk, rst_n, cmd.refresh |-> $past(cmd.exec))
    `ASSERT_CLK(a_popped_is_ok, clk, rst_n, (rsp.valid && rsp.out_valid) |-> (rsp.status == kwsm_pkg::ST_OK))
    `ASSERT_CLK(a_no_pop_zero, clk, rst_n, (rsp.valid && !rsp.out_valid) |-> (rsp.out_value == '0))

endmodule

/* rtl/core/kwsm_ctrl.sv */
// ----------------------------------------------------------------------------
// kwsm_ctrl
// Sequencer: takes a transaction, runs it, refreshes a list front after a pop that leaves it non-empty.
// ----------------------------------------------------------------------------
module kwsm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output kwsm_pkg::ctrl_cmd_t   cmd,
    input  kwsm_pkg::dp_stat_t    stat
);

    kwsm_pkg::state_t state_reg;
    kwsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kwsm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            kwsm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = kwsm_pkg::S_EXEC;
                end
            end
            kwsm_pkg::S_EXEC:
            begin
                // wait for a free result slot
                if (!stat.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.needs_refresh ? kwsm_pkg::S_REFRESH
                                                    : kwsm_pkg::S_IDLE;
                end
            end
            kwsm_pkg::S_REFRESH:
            begin
                cmd.refresh = 1'b1;
                state_next  = kwsm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = kwsm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/kwsm_dp.sv */
// ----------------------------------------------------------------------------
// kwsm_dp
// Datapath: list counters, cached fronts, min tree, element memory, result reg.
// ----------------------------------------------------------------------------
module kwsm_dp #(
    parameter int NUM_LISTS   = 8,
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kwsm_pkg::ctrl_cmd_t                   cmd,
    output kwsm_pkg::dp_stat_t                    stat,
    input  logic [kwsm_pkg::OP_WIDTH-1:0]         op,
    input  logic [kwsm_pkg::INDEX_WIDTH-1:0]      list_index,
    input  logic signed [VALUE_WIDTH-1:0]         value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic signed [VALUE_WIDTH-1:0]         out_value,
    output logic                                  out_valid,
    output logic [kwsm_pkg::STATUS_WIDTH-1:0]     status
);

    localparam int LW        = $clog2(NUM_LISTS);
    localparam int P         = 1 << LW;
    localparam int SW        = $clog2(LIST_DEPTH);
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int TW        = ((SW > CW) ? SW : CW) + 1;
    localparam int IXW       = (LW > kwsm_pkg::INDEX_WIDTH) ? LW : kwsm_pkg::INDEX_WIDTH;
    localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    logic [kwsm_pkg::OP_WIDTH-1:0]     op_reg;
    logic [kwsm_pkg::INDEX_WIDTH-1:0]  idx_reg;
    logic signed [VALUE_WIDTH-1:0]     val_reg;

    logic [SW-1:0]                     fp_reg  [NUM_LISTS];
    logic [CW-1:0]                     cnt_reg [NUM_LISTS];
    logic signed [VALUE_WIDTH-1:0]     fv_reg  [NUM_LISTS];

    logic signed [VALUE_WIDTH-1:0]     mem [MEM_DEPTH];
    logic signed [VALUE_WIDTH-1:0]     rd_reg;
    logic [LW-1:0]                     best_reg;

    logic                              out_vld_reg;
    logic signed [VALUE_WIDTH-1:0]     out_value_reg;
    logic                              out_valid_reg;
    logic [kwsm_pkg::STATUS_WIDTH-1:0] status_reg;

    // min tree, ties resolve to the lower index
    logic                              leaf_v   [P];
    logic signed [VALUE_WIDTH-1:0]     leaf_val [P];
    logic [LW-1:0]                     leaf_ix  [P];
    logic                              tv   [LW+1][P];
    logic signed [VALUE_WIDTH-1:0]     tval [LW+1][P];
    logic [LW-1:0]                     tix  [LW+1][P];

    logic                              root_v;
    logic signed [VALUE_WIDTH-1:0]     root_val;
    logic [LW-1:0]                     best;

    logic                              is_load;
    logic                              is_pop;
    logic                              is_clear;
    logic [IXW-1:0]                    idx_ext;
    logic [LW-1:0]                     lsel;
    logic                              idx_ok;
    logic [LW-1:0]                     sel;
    logic [SW-1:0]                     fp_sel;
    logic [CW-1:0]                     cnt_sel;
    logic                              full;
    logic                              load_ok;
    logic [TW-1:0]                     tail_sum;
    logic [TW-1:0]                     tail_wrap;
    logic [SW-1:0]                     tail_slot;
    logic [SW-1:0]                     nfp;
    logic [AW-1:0]                     wr_addr;
    logic [AW-1:0]                     rd_addr;
    logic                              mem_we;

    for (genvar j = 0; j < P; j++)
    begin : g_leaf
        if (j < NUM_LISTS)
        begin : g_used
            assign leaf_v[j]   = (cnt_reg[j] != '0);
            assign leaf_val[j] = fv_reg[j];
        end
        else
        begin : g_pad
            assign leaf_v[j]   = 1'b0;
            assign leaf_val[j] = '0;
        end
        assign leaf_ix[j] = LW'(j);
    end

    always_comb
    begin
        logic pick_r;
        pick_r = 1'b0;
        for (int l = 0; l <= LW; l++)
        begin
            for (int j = 0; j < P; j++)
            begin
                tv[l][j]   = 1'b0;
                tval[l][j] = '0;
                tix[l][j]  = '0;
            end
        end
        for (int j = 0; j < P; j++)
        begin
            tv[0][j]   = leaf_v[j];
            tval[0][j] = leaf_val[j];
            tix[0][j]  = leaf_ix[j];
        end
        for (int l = 0; l < LW; l++)
        begin
            for (int j = 0; j < (P >> (l + 1)); j++)
            begin
                pick_r = tv[l][2*j+1] &&
                         (!tv[l][2*j] || (tval[l][2*j+1] < tval[l][2*j]));
                tv[l+1][j]   = tv[l][2*j] || tv[l][2*j+1];
                tval[l+1][j] = pick_r ? tval[l][2*j+1] : tval[l][2*j];
                tix[l+1][j]  = pick_r ? tix[l][2*j+1]  : tix[l][2*j];
            end
        end
    end

    assign root_v   = tv[LW][0];
    assign root_val = tval[LW][0];
    assign best     = tix[LW][0];

    assign is_load  = (op_reg == kwsm_pkg::OP_LOAD);
    assign is_pop   = (op_reg == kwsm_pkg::OP_POP);
    assign is_clear = (op_reg == kwsm_pkg::OP_CLEAR);

    assign idx_ext  = IXW'(idx_reg);
    assign lsel     = idx_ext[LW-1:0];
    assign idx_ok   = ((IXW+1)'(idx_reg) < (IXW+1)'(NUM_LISTS));

    assign sel      = is_pop ? best : lsel;
    assign fp_sel   = fp_reg[sel];
    assign cnt_sel  = cnt_reg[sel];

    assign full      = (cnt_sel == CW'(LIST_DEPTH));
    assign load_ok   = idx_ok && !full;
    assign tail_sum  = TW'(fp_sel) + TW'(cnt_sel);
    assign tail_wrap = (tail_sum >= TW'(LIST_DEPTH)) ? (tail_sum - TW'(LIST_DEPTH))
                                                      : tail_sum;
    assign tail_slot = tail_wrap[SW-1:0];
    assign nfp       = (fp_sel == SW'(LIST_DEPTH - 1)) ? '0 : (fp_sel + SW'(1));

    assign wr_addr = AW'(lsel) * AW'(LIST_DEPTH) + AW'(tail_slot);
    assign rd_addr = AW'(best) * AW'(LIST_DEPTH) + AW'(nfp);
    assign mem_we  = cmd.exec && is_load && load_ok;

    assign stat.out_busy      = out_vld_reg && !rsp_ready;
    assign stat.needs_refresh = is_pop && root_v && (cnt_sel != CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                fp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
                fv_reg[i]  <= '0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (is_load && load_ok)
                begin
                    cnt_reg[lsel] <= cnt_sel + CW'(1);
                    if (cnt_sel == '0)
                    begin
                        fv_reg[lsel] <= val_reg;
                    end
                end
                if (is_pop && root_v)
                begin
                    fp_reg[best]  <= nfp;
                    cnt_reg[best] <= cnt_sel - CW'(1);
                end
                if (is_clear)
                begin
                    for (int i = 0; i < NUM_LISTS; i++)
                    begin
                        fp_reg[i]  <= '0;
                        cnt_reg[i] <= '0;
                        fv_reg[i]  <= '0;
                    end
                end
            end
            if (cmd.refresh)
            begin
                fv_reg[best_reg] <= rd_reg;
            end
            if (cmd.exec)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            idx_reg <= list_index;
            val_reg <= value;
        end
        if (mem_we)
        begin
            mem[wr_addr] <= val_reg;
        end
        rd_reg <= mem[rd_addr];
        if (cmd.exec)
        begin
            best_reg      <= best;
            out_value_reg <= (is_pop && root_v) ? root_val : '0;
            out_valid_reg <= is_pop && root_v;
            if (is_load && !load_ok)
            begin
                status_reg <= kwsm_pkg::ST_FULL;
            end
            else if (is_pop && !root_v)
            begin
                status_reg <= kwsm_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg <= kwsm_pkg::ST_OK;
            end
        end
    end

    assign rsp_valid = out_vld_reg;
    assign out_value = out_value_reg;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule
